[rtl/core/terminal_cell_buffer_assert.svh]
// Assertion macros shared by the terminal cell buffer RTL.
// Depends on nothing; included by the top level.
`ifndef TERMINAL_CELL_BUFFER_ASSERT_SVH
`define TERMINAL_CELL_BUFFER_ASSERT_SVH
// Checks that a condition implies another on the same edge.
`define TCB_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcb implication failed");
// Checks that a condition implies another on the next edge.
`define TCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcb next-cycle check failed");
`endif

[rtl/core/tcb_pkg.sv]
// Package for the terminal cell buffer: sizes, action codes and shared types.
// Depends on nothing.
`timescale 1ns / 1ps
package tcb_pkg;
    localparam int MaxCols = 128;
    localparam int MaxRows = 64;
    localparam int ColW = $clog2(MaxCols);
    localparam int RowW = $clog2(MaxRows);
    localparam int AddrW = ColW + RowW;
    localparam int CellW = 20;
    localparam logic [7:0] BlankChar = 8'h20;

    typedef enum logic [3:0] {
        ACT_WRITE = 4'd0, ACT_SETCOL = 4'd1, ACT_SETROW = 4'd2, ACT_MOVECOL = 4'd3,
        ACT_MOVEROW = 4'd4, ACT_READ = 4'd5, ACT_ERASEALL = 4'd6,
        ACT_ERASEBELOW = 4'd7, ACT_ERASERIGHT = 4'd8, ACT_DELLINES = 4'd9,
        ACT_DELCHARS = 4'd10, ACT_ATTR = 4'd11, ACT_ENABLE = 4'd12,
        ACT_CHANGED = 4'd13, ACT_NOP14 = 4'd14, ACT_NOP15 = 4'd15
    } action_t;

    // Command handed from the front end to the cell engine.
    typedef enum logic [2:0] {
        OP_NONE, OP_WRITE, OP_READ, OP_FILL, OP_COPY
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ColW-1:0]  col;      // write/read column, or start column
        logic [RowW-1:0]  row;
        logic [ColW:0]    col_end;  // one past last column of a pass
        logic [RowW:0]    row_end;  // one past last row of a pass
        logic [ColW:0]    col_wrap; // first column of rows after the first
        logic [RowW:0]    src_dr;   // copy source row offset
        logic [ColW:0]    src_dc;   // copy source column offset
        logic [CellW-1:0] data;
        logic [ColW-1:0]  res_col;
        logic [RowW-1:0]  res_row;
        logic             hit;
        logic             chg;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RUN, ST_READ, ST_RESULT
    } eng_state_t;
endpackage

[rtl/core/tcb_front.sv]
// Front end: cursor, attribute and flag state; turns each action into engine commands.
// Depends on tcb_pkg.
`timescale 1ns / 1ps
module tcb_front
    import tcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              accept,
    input  logic [3:0]        action,
    input  logic [7:0]        char_code,
    input  logic [7:0]        position,
    input  logic signed [8:0] amount,
    input  logic [7:0]        read_col,
    input  logic [7:0]        read_row,
    input  logic [7:0]        count,
    input  logic [11:0]       attribute,
    input  logic              enable,
    output logic              push,
    output cmd_t              cmd
);
    logic [7:0]      width_reg;
    logic [6:0]      height_reg;
    logic [ColW-1:0] col_reg, col_next;
    logic [RowW-1:0] row_reg, row_next;
    logic [11:0]     attr_reg;
    logic            dirty_reg, allowed_reg, first_reg;
    logic [ColW:0]   w;
    logic [RowW:0]   h;
    logic signed [10:0] t;
    logic [7:0]      pm1;
    logic [ColW:0]   nc;
    logic [RowW:0]   nr;
    logic [8:0]      ncap;
    logic [CellW-1:0] blank;

    always_comb
    begin
        w = (width_reg == 8'd0) ? (ColW+1)'(1)
          : (width_reg > 8'(MaxCols)) ? (ColW+1)'(MaxCols) : width_reg[ColW:0];
        h = (height_reg == 7'd0) ? (RowW+1)'(1)
          : (height_reg > 7'(MaxRows)) ? (RowW+1)'(MaxRows) : height_reg[RowW:0];
    end

    assign blank = {attr_reg, BlankChar};
    assign pm1 = position - 8'd1;

    always_comb
    begin
        cmd = '0;
        cmd.op = OP_NONE;
        cmd.data = blank;
        col_next = col_reg;
        row_next = row_reg;
        t = '0;
        nc = '0;
        nr = '0;
        ncap = '0;
        push = accept;
        unique case (action_t'(action))
            ACT_WRITE:
            begin
                cmd.op = OP_WRITE;
                cmd.col = col_reg;
                cmd.row = row_reg;
                cmd.data = {attr_reg, char_code};
                nc = {1'b0, col_reg} + 1'b1;
                if (nc >= w)
                begin
                    col_next = '0;
                    nr = {1'b0, row_reg} + 1'b1;
                    if (nr >= h)
                    begin
                        row_next = RowW'(h - 1'b1);
                        cmd.hit = 1'b1;
                    end
                    else
                        row_next = nr[RowW-1:0];
                end
                else
                    col_next = nc[ColW-1:0];
            end
            ACT_SETCOL:
                if (position != 8'd0)
                begin
                    if ({1'b0, pm1} >= 9'(w))
                    begin
                        col_next = ColW'(w - 1'b1);
                        cmd.hit = 1'b1;
                    end
                    else
                        col_next = pm1[ColW-1:0];
                end
            ACT_SETROW:
                if (position != 8'd0)
                begin
                    if ({1'b0, pm1} >= 9'(h))
                    begin
                        row_next = RowW'(h - 1'b1);
                        cmd.hit = 1'b1;
                    end
                    else
                        row_next = pm1[RowW-1:0];
                end
            ACT_MOVECOL:
            begin
                t = 11'(signed'({1'b0, col_reg})) + 11'(amount);
                if (t < 0)
                begin
                    col_next = '0;
                    cmd.hit = 1'b1;
                end
                else if (t >= 11'(w))
                begin
                    col_next = ColW'(w - 1'b1);
                    cmd.hit = 1'b1;
                end
                else
                    col_next = t[ColW-1:0];
            end
            ACT_MOVEROW:
            begin
                t = 11'(signed'({1'b0, row_reg})) + 11'(amount);
                if (t < 0)
                begin
                    row_next = '0;
                    cmd.hit = 1'b1;
                end
                else if (t >= 11'(h))
                begin
                    row_next = RowW'(h - 1'b1);
                    cmd.hit = 1'b1;
                end
                else
                    row_next = t[RowW-1:0];
            end
            ACT_READ:
            begin
                cmd.op = OP_READ;
                if ({1'b0, read_col} >= 9'(w))
                begin
                    cmd.col = ColW'(w - 1'b1);
                    cmd.hit = 1'b1;
                end
                else
                    cmd.col = read_col[ColW-1:0];
                if ({1'b0, read_row} >= 9'(h))
                begin
                    cmd.row = RowW'(h - 1'b1);
                    cmd.hit = 1'b1;
                end
                else
                    cmd.row = read_row[RowW-1:0];
            end
            ACT_ERASEALL:
                if (allowed_reg || first_reg)
                begin
                    cmd.op = OP_FILL;
                    cmd.col_end = w;
                    cmd.row_end = h;
                end
            ACT_ERASEBELOW, ACT_ERASERIGHT:
            begin
                cmd.op = OP_FILL;
                cmd.col = col_reg;
                cmd.row = row_reg;
                cmd.col_end = w;
                cmd.row_end = (action_t'(action) == ACT_ERASERIGHT)
                            ? (RowW+1)'(row_reg) + 1'b1 : h;
            end
            ACT_DELLINES:
            begin
                // Rows move up by the capped count, then blanks fill the bottom.
                ncap = 9'(h) - 9'(row_reg);
                if (9'(count) < ncap)
                    ncap = 9'(count);
                cmd.op = OP_COPY;
                cmd.row = row_reg;
                cmd.col_end = w;
                cmd.row_end = h;
                cmd.src_dr = ncap[RowW:0];
            end
            ACT_DELCHARS:
            begin
                ncap = 9'(w) - 9'(col_reg);
                if (9'(count) < ncap)
                    ncap = 9'(count);
                cmd.op = OP_COPY;
                cmd.col = col_reg;
                cmd.row = row_reg;
                cmd.col_end = w;
                cmd.row_end = (RowW+1)'(row_reg) + 1'b1;
                cmd.col_wrap = (ColW+1)'(col_reg);
                cmd.src_dc = ncap[ColW:0];
            end
            ACT_CHANGED:
                cmd.chg = dirty_reg;
            default: ;
        endcase
        cmd.res_col = col_next;
        cmd.res_row = row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 8'd80;
            height_reg <= 7'd24;
            col_reg <= '0;
            row_reg <= '0;
            attr_reg <= '0;
            dirty_reg <= 1'b1;
            allowed_reg <= 1'b1;
            first_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            // Shrinking the screen pulls the cursor inside at once.
            if (cfg_index == 8'd0)
            begin
                width_reg <= cfg_data;
                if (cfg_data == 8'd0)
                    col_reg <= '0;
                else if ({1'b0, col_reg} >= cfg_data)
                    col_reg <= ColW'(cfg_data - 8'd1);
            end
            else if (cfg_index == 8'd1)
            begin
                height_reg <= cfg_data[6:0];
                if (cfg_data[6:0] == 7'd0)
                    row_reg <= '0;
                else if (7'(row_reg) >= cfg_data[6:0])
                    row_reg <= RowW'(cfg_data[6:0] - 7'd1);
            end
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            unique case (action_t'(action))
                ACT_WRITE, ACT_ERASEBELOW, ACT_ERASERIGHT, ACT_DELLINES, ACT_DELCHARS:
                    dirty_reg <= 1'b1;
                ACT_ERASEALL:
                    if (allowed_reg || first_reg)
                    begin
                        first_reg <= 1'b0;
                        dirty_reg <= 1'b1;
                    end
                ACT_ATTR:
                    attr_reg <= attribute;
                ACT_ENABLE:
                begin
                    allowed_reg <= enable;
                    if (!enable)
                        first_reg <= 1'b1;
                end
                ACT_CHANGED:
                    dirty_reg <= 1'b0;
                default: ;
            endcase
        end
    end
endmodule

[rtl/core/tcb_queue.sv]
// Two-entry command queue between the front end and the cell engine.
// Depends on tcb_pkg.
`timescale 1ns / 1ps
module tcb_queue
    import tcb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic not_empty,
    output logic full,
    output cmd_t head
);
    cmd_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign not_empty = (cnt_reg != 2'd0);
    assign full = (cnt_reg == 2'd2);
    assign head = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[rtl/core/tcb_engine.sv]
// Cell engine: owns the cell memory, runs writes, reads, fills and copies.
// Depends on tcb_pkg.
`timescale 1ns / 1ps
module tcb_engine
    import tcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              not_empty,
    input  cmd_t              head,
    output logic              pop,
    output logic              ready,
    output logic              strobe,
    output logic [7:0]        cell_char,
    output logic [11:0]       cell_attribute,
    output logic [ColW-1:0]   cursor_col,
    output logic [RowW-1:0]   cursor_row,
    output logic              bounds_hit,
    output logic              changed
);
    logic [CellW-1:0] mem [1 << AddrW];
    logic [CellW-1:0] rdata_reg;
    eng_state_t state_reg, state_next;
    cmd_t       cur_reg;
    logic [ColW:0] c_reg, c_next;
    logic [RowW:0] r_reg, r_next;
    logic [AddrW:0] clr_reg;
    logic       phase_reg;   // copy: 0 reads source, 1 writes destination
    logic       we;
    logic [AddrW-1:0] waddr, raddr;
    logic [CellW-1:0] wdata;
    logic       re;
    logic [ColW:0] sc;
    logic [RowW:0] sr;
    logic       src_in;
    logic       last;

    assign sc = c_reg + cur_reg.src_dc;
    assign sr = r_reg + cur_reg.src_dr;
    assign src_in = (sc < cur_reg.col_end) && (sr < cur_reg.row_end);
    assign last = (c_next == '0) && (r_next == '0);

    // Step over columns, then rows.
    always_comb
    begin
        c_next = c_reg + 1'b1;
        r_next = r_reg;
        if (c_next >= cur_reg.col_end)
        begin
            c_next = cur_reg.col_wrap;
            r_next = r_reg + 1'b1;
        end
        if (r_next >= cur_reg.row_end)
        begin
            c_next = '0;
            r_next = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == (AddrW+1)'((1 << AddrW) - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (not_empty)
                begin
                    unique case (head.op)
                        OP_READ: state_next = ST_READ;
                        OP_FILL, OP_COPY: state_next = ST_RUN;
                        default: state_next = ST_IDLE;
                    endcase
                end
            ST_RUN:
                if ((cur_reg.op == OP_FILL || phase_reg || !src_in) && last)
                    state_next = ST_RESULT;
            ST_READ:
                state_next = ST_RESULT;
            ST_RESULT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        re = 1'b0;
        waddr = {r_reg[RowW-1:0], c_reg[ColW-1:0]};
        raddr = {sr[RowW-1:0], sc[ColW-1:0]};
        wdata = cur_reg.data;
        pop = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg[AddrW-1:0];
                wdata = {12'd0, BlankChar};
            end
            ST_IDLE:
            begin
                pop = not_empty;
                raddr = {head.row, head.col};
                re = not_empty && (head.op == OP_READ);
                if (not_empty && head.op == OP_WRITE)
                begin
                    we = 1'b1;
                    waddr = {head.row, head.col};
                    wdata = head.data;
                end
            end
            ST_RUN:
                if (cur_reg.op == OP_FILL)
                    we = 1'b1;
                else if (!src_in)
                    we = 1'b1;
                else if (phase_reg)
                begin
                    we = 1'b1;
                    wdata = rdata_reg;
                end
                else
                    re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            c_reg <= '0;
            r_reg <= '0;
            phase_reg <= 1'b0;
            strobe <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            strobe <= 1'b0;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_IDLE && not_empty)
            begin
                c_reg <= (ColW+1)'(head.col);
                r_reg <= (RowW+1)'(head.row);
                phase_reg <= 1'b0;
                if (head.op == OP_WRITE || head.op == OP_NONE)
                    strobe <= 1'b1;
            end
            if (state_reg == ST_RUN)
            begin
                if (cur_reg.op == OP_COPY && src_in && !phase_reg)
                    phase_reg <= 1'b1;
                else
                begin
                    phase_reg <= 1'b0;
                    c_reg <= c_next;
                    r_reg <= r_next;
                end
            end
            if (state_reg == ST_RESULT)
                strobe <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && not_empty)
        begin
            cur_reg <= head;
            cursor_col <= head.res_col;
            cursor_row <= head.res_row;
            bounds_hit <= head.hit;
            changed <= head.chg;
            cell_char <= 8'd0;
            cell_attribute <= 12'd0;
        end
        if (state_reg == ST_RESULT && cur_reg.op == OP_READ)
        begin
            cell_char <= rdata_reg[7:0];
            cell_attribute <= rdata_reg[19:8];
        end
    end

    assign ready = (state_reg == ST_IDLE) && !not_empty;
endmodule

[rtl/core/terminal_cell_buffer.sv]
// Top level of the terminal cell buffer: front end, command queue and cell engine.
// Depends on tcb_pkg, tcb_front, tcb_queue, tcb_engine and the assertion header.
`timescale 1ns / 1ps
`include "terminal_cell_buffer_assert.svh"
// A character-cell screen store with a cursor. A command is taken when start is
// high and busy low; its fields sit on their own ports. One result per command
// shows on the result ports for one cycle with done high; the receiver cannot
// stall, so done is never held. Writes, cursor moves, attribute, gate and flag
// commands return a result as soon as the engine takes them from the queue; a
// read passes through a read and a result state. Fills write each covered cell
// in turn; line and character deletes read and then write each moved cell and
// write each blank cell; both end in the result state. busy stays high up to
// the edge that takes the result, so one command is in work at a time and the
// next transfer can come at the edge after that. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and are legal only while idle. After
// reset a clearing pass writes all 8192 cells to blank, with busy high;
// configuration is still taken.
module terminal_cell_buffer
    import tcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [3:0]        action,
    input  logic [7:0]        char_code,
    input  logic [7:0]        position,
    input  logic signed [8:0] amount,
    input  logic [7:0]        read_col,
    input  logic [7:0]        read_row,
    input  logic [7:0]        count,
    input  logic [11:0]       attribute,
    input  logic              enable,
    output logic              done,
    output logic [7:0]        cell_char,
    output logic [11:0]       cell_attribute,
    output logic [6:0]        cursor_col,
    output logic [5:0]        cursor_row,
    output logic              bounds_hit,
    output logic              changed
);
    logic accept, push, pop, not_empty, full, ready;
    logic busy_reg;
    cmd_t fcmd, hcmd;

    assign busy = busy_reg || !ready || full;
    assign accept = start && !busy;

    // Hold busy from a transfer until the engine reports ready again.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= accept || (busy_reg && !ready);
    end

    tcb_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .accept, .action, .char_code,
        .position, .amount, .read_col, .read_row, .count, .attribute, .enable,
        .push, .cmd(fcmd)
    );

    tcb_queue u_queue (
        .clk, .rst_n, .push, .push_cmd(fcmd), .pop, .not_empty, .full, .head(hcmd)
    );

    tcb_engine u_engine (
        .clk, .rst_n, .not_empty, .head(hcmd), .pop, .ready, .strobe(done),
        .cell_char, .cell_attribute, .cursor_col, .cursor_row, .bounds_hit, .changed
    );

    `TCB_ASSERT_IMPLY(a_no_push_full, push, !full)
    `TCB_ASSERT_NEXT(a_accept_busy, accept, busy)
    `TCB_ASSERT_IMPLY(a_done_not_idle_start, done, !accept)
endmodule

[sim/tb.sv]
// Self-checking testbench for the terminal cell buffer.
// Depends on tcb_pkg and the terminal_cell_buffer RTL; a screen predictor checks every result.
`timescale 1ns / 1ps
module tb;
    import tcb_pkg::*;

    localparam int Limit = 2000000;

    typedef struct {
        logic [3:0]        action;
        logic [7:0]        char_code;
        logic [7:0]        position;
        logic signed [8:0] amount;
        logic [7:0]        read_col;
        logic [7:0]        read_row;
        logic [7:0]        count;
        logic [11:0]       attribute;
        logic              enable;
    } cmd_item_t;

    typedef struct {
        logic [7:0]  ch;
        logic [11:0] attr;
        logic [6:0]  col;
        logic [5:0]  row;
        logic        hit;
        logic        chg;
    } screen_res_t;

    typedef struct {
        cmd_item_t   it;
        bit          has_exp;
        screen_res_t exp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [3:0] action = '0;
    logic [7:0] char_code = '0;
    logic [7:0] position = '0;
    logic signed [8:0] amount = '0;
    logic [7:0] read_col = '0;
    logic [7:0] read_row = '0;
    logic [7:0] count = '0;
    logic [11:0] attribute = '0;
    logic enable = 1'b0;
    logic done;
    logic [7:0] cell_char;
    logic [11:0] cell_attribute;
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic bounds_hit;
    logic changed;

    terminal_cell_buffer i_dut (.*);

    always #5 clk = ~clk;

    // Predicted screen contents and control state.
    logic [19:0] screen [0:MaxRows-1][0:MaxCols-1];
    int          width_reg = 80;
    int          height_reg = 24;
    int          cur_c = 0;
    int          cur_r = 0;
    logic [11:0] wr_attr = '0;
    bit          dirty = 1'b1;
    bit          erase_ok = 1'b1;
    bit          erase_armed = 1'b1;

    screen_res_t pending_results[$];
    dir_row_t    directed[$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;

    function automatic int cols_used();
        return (width_reg < 1) ? 1 : (width_reg > MaxCols) ? MaxCols : width_reg;
    endfunction

    function automatic int rows_used();
        return (height_reg < 1) ? 1 : (height_reg > MaxRows) ? MaxRows : height_reg;
    endfunction

    function automatic void blank_cells(int r0, int r1, int c0, int c1);
        for (int r = r0; r < r1; r++)
            for (int c = c0; c < c1; c++)
                screen[r][c] = {wr_attr, BlankChar};
    endfunction

    function automatic int clamp_move(int pos, int delta, int lim, ref logic hit);
        int t;
        t = pos + delta;
        if (t < 0) begin
            hit = 1'b1;
            return 0;
        end
        if (t >= lim) begin
            hit = 1'b1;
            return lim - 1;
        end
        return t;
    endfunction

    function automatic screen_res_t apply_cmd(cmd_item_t it);
        screen_res_t res;
        int w;
        int h;
        int n;
        int rc;
        int rr;
        logic [19:0] rd_word;
        w = cols_used();
        h = rows_used();
        res = '{default: '0};
        case (it.action)
            ACT_WRITE: begin
                screen[cur_r][cur_c] = {wr_attr, it.char_code};
                cur_c++;
                if (cur_c >= w) begin
                    cur_c = 0;
                    cur_r++;
                    if (cur_r >= h) begin
                        cur_r = h - 1;
                        res.hit = 1'b1;
                    end
                end
                dirty = 1'b1;
            end
            ACT_SETCOL: if (it.position != 0) begin
                cur_c = int'(it.position) - 1;
                if (cur_c >= w) begin
                    cur_c = w - 1;
                    res.hit = 1'b1;
                end
            end
            ACT_SETROW: if (it.position != 0) begin
                cur_r = int'(it.position) - 1;
                if (cur_r >= h) begin
                    cur_r = h - 1;
                    res.hit = 1'b1;
                end
            end
            ACT_MOVECOL: cur_c = clamp_move(cur_c, int'(it.amount), w, res.hit);
            ACT_MOVEROW: cur_r = clamp_move(cur_r, int'(it.amount), h, res.hit);
            ACT_READ: begin
                rc = int'(it.read_col);
                rr = int'(it.read_row);
                if (rc >= w) begin
                    rc = w - 1;
                    res.hit = 1'b1;
                end
                if (rr >= h) begin
                    rr = h - 1;
                    res.hit = 1'b1;
                end
                rd_word = screen[rr][rc];
                res.ch = rd_word[7:0];
                res.attr = rd_word[19:8];
            end
            ACT_ERASEALL: if (erase_ok || erase_armed) begin
                erase_armed = 1'b0;
                blank_cells(0, h, 0, w);
                dirty = 1'b1;
            end
            ACT_ERASEBELOW: begin
                blank_cells(cur_r, cur_r + 1, cur_c, w);
                blank_cells(cur_r + 1, h, 0, w);
                dirty = 1'b1;
            end
            ACT_ERASERIGHT: begin
                blank_cells(cur_r, cur_r + 1, cur_c, w);
                dirty = 1'b1;
            end
            ACT_DELLINES: begin
                n = (int'(it.count) > h - cur_r) ? h - cur_r : int'(it.count);
                for (int r = cur_r; r + n < h; r++)
                    for (int c = 0; c < w; c++)
                        screen[r][c] = screen[r + n][c];
                blank_cells(h - n, h, 0, w);
                dirty = 1'b1;
            end
            ACT_DELCHARS: begin
                n = (int'(it.count) > w - cur_c) ? w - cur_c : int'(it.count);
                for (int c = cur_c; c + n < w; c++)
                    screen[cur_r][c] = screen[cur_r][c + n];
                blank_cells(cur_r, cur_r + 1, w - n, w);
                dirty = 1'b1;
            end
            ACT_ATTR: wr_attr = it.attribute;
            ACT_ENABLE: begin
                erase_ok = it.enable;
                if (!it.enable)
                    erase_armed = 1'b1;
            end
            ACT_CHANGED: begin
                res.chg = dirty;
                dirty = 1'b0;
            end
            default: ;
        endcase
        res.col = cur_c[6:0];
        res.row = cur_r[5:0];
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > Limit) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        screen_res_t e;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = pending_results.pop_front();
                if (cell_char !== e.ch)
                    report("cell_char", int'(cell_char), int'(e.ch));
                if (cell_attribute !== e.attr)
                    report("cell_attribute", int'(cell_attribute), int'(e.attr));
                if (cursor_col !== e.col)
                    report("cursor_col", int'(cursor_col), int'(e.col));
                if (cursor_row !== e.row)
                    report("cursor_row", int'(cursor_row), int'(e.row));
                if (bounds_hit !== e.hit)
                    report("bounds_hit", int'(bounds_hit), int'(e.hit));
                if (changed !== e.chg)
                    report("changed", int'(changed), int'(e.chg));
            end
        end
    end

    // Drives one command and holds it until the transfer happens.
    task automatic send(cmd_item_t it, bit has_exp, screen_res_t want);
        screen_res_t p;
        start <= 1'b1;
        action <= it.action;
        char_code <= it.char_code;
        position <= it.position;
        amount <= it.amount;
        read_col <= it.read_col;
        read_row <= it.read_row;
        count <= it.count;
        attribute <= it.attribute;
        enable <= it.enable;
        do @(posedge clk); while (busy);
        p = apply_cmd(it);
        if (has_exp)
            p = want;
        pending_results = {pending_results, p};
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Waits until the block is idle, then loads both size registers.
    task automatic set_screen(int w, int h);
        @(posedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 8'd0;
        cfg_data <= w[7:0];
        @(posedge clk);
        width_reg = w & 8'hff;
        cfg_index <= 8'd1;
        cfg_data <= h[7:0];
        @(posedge clk);
        height_reg = h & 8'h7f;
        cfg_we <= 1'b0;
        if (cur_c >= cols_used()) cur_c = cols_used() - 1;
        if (cur_r >= rows_used()) cur_r = rows_used() - 1;
    endtask

    function automatic dir_row_t cmd(logic [3:0] a, int v);
        dir_row_t d;
        d.it = '{default: '0};
        d.it.action = a;
        d.has_exp = 1'b0;
        d.exp = '{default: '0};
        case (a)
            ACT_WRITE: d.it.char_code = v[7:0];
            ACT_SETCOL, ACT_SETROW: d.it.position = v[7:0];
            ACT_MOVECOL, ACT_MOVEROW: d.it.amount = v[8:0];
            ACT_READ: begin
                d.it.read_col = v[7:0];
                d.it.read_row = v[15:8];
            end
            ACT_DELLINES, ACT_DELCHARS: d.it.count = v[7:0];
            ACT_ATTR: d.it.attribute = v[11:0];
            ACT_ENABLE: d.it.enable = v[0];
            default: ;
        endcase
        return d;
    endfunction

    function automatic dir_row_t known(dir_row_t d, int ch, int at, int c, int r, int hit,
                                       int chg);
        d.has_exp = 1'b1;
        d.exp = '{ch[7:0], at[11:0], c[6:0], r[5:0], hit[0], chg[0]};
        return d;
    endfunction

    function automatic cmd_item_t random_cmd();
        cmd_item_t it;
        int p;
        int w;
        int h;
        bit heavy;
        w = cols_used();
        h = rows_used();
        heavy = (w * h > 512);
        it.char_code = 8'($urandom_range(0, 255));
        it.position = ($urandom_range(0, 1)) ? 8'($urandom_range(0, w + 1))
                                             : 8'($urandom_range(0, 255));
        it.amount = ($urandom_range(0, 1)) ? 9'($urandom_range(0, 2 * w + 2) - (w + 1))
                                           : 9'($urandom_range(0, 510) - 255);
        it.read_col = ($urandom_range(0, 1)) ? 8'($urandom_range(0, w))
                                             : 8'($urandom_range(0, 255));
        it.read_row = ($urandom_range(0, 1)) ? 8'($urandom_range(0, h))
                                             : 8'($urandom_range(0, 255));
        it.count = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 4))
                                               : 8'($urandom_range(0, 255));
        it.attribute = 12'($urandom_range(0, 4095));
        it.enable = 1'($urandom_range(0, 1));
        p = $urandom_range(0, 99);
        if (p < 30) it.action = ACT_WRITE;
        else if (p < 38) it.action = $urandom_range(0, 1) ? ACT_SETCOL : ACT_SETROW;
        else if (p < 50) it.action = $urandom_range(0, 1) ? ACT_MOVECOL : ACT_MOVEROW;
        else if (p < 62) it.action = ACT_READ;
        else if (p < 70) it.action = ACT_ATTR;
        else if (p < 74) it.action = ACT_ENABLE;
        else if (p < 78) it.action = ACT_CHANGED;
        else if (p < 80) it.action = $urandom_range(0, 1) ? ACT_NOP14 : ACT_NOP15;
        else if (heavy && $urandom_range(0, 9) != 0) it.action = ACT_WRITE;
        else it.action = 4'($urandom_range(ACT_ERASEALL, ACT_DELCHARS));
        return it;
    endfunction

    initial begin
        int sizes [12][2] = '{'{1, 1}, '{128, 64}, '{0, 0}, '{255, 127}, '{8, 4},
                              '{16, 8}, '{3, 2}, '{40, 12}, '{5, 64}, '{128, 1},
                              '{1, 64}, '{12, 6}};
        int n;
        for (int r = 0; r < MaxRows; r++)
            for (int c = 0; c < MaxCols; c++)
                screen[r][c] = {12'h000, BlankChar};

        directed = {directed, known(cmd(ACT_CHANGED, 0), 0, 0, 0, 0, 0, 1)};
        directed = {directed, known(cmd(ACT_CHANGED, 0), 0, 0, 0, 0, 0, 0)};
        directed = {directed, known(cmd(ACT_READ, 16'hffff), 8'h20, 0, 0, 0, 1, 0)};
        directed = {directed, cmd(ACT_ATTR, 12'hfff)};
        directed = {directed, cmd(ACT_WRITE, 8'hff)};
        directed = {directed, cmd(ACT_WRITE, 8'h00)};
        directed = {directed, cmd(ACT_SETCOL, 0)};
        directed = {directed, known(cmd(ACT_SETCOL, 255), 0, 0, 79, 0, 1, 0)};
        directed = {directed, known(cmd(ACT_WRITE, 8'h41), 0, 0, 0, 1, 0, 0)};
        directed = {directed, known(cmd(ACT_SETROW, 255), 0, 0, 0, 23, 1, 0)};
        directed = {directed, cmd(ACT_SETCOL, 80)};
        // Write in the bottom right cell stays on the last row.
        directed = {directed, known(cmd(ACT_WRITE, 8'h5a), 0, 0, 0, 23, 1, 0)};
        directed = {directed, known(cmd(ACT_MOVECOL, -255), 0, 0, 0, 23, 1, 0)};
        directed = {directed, known(cmd(ACT_MOVEROW, 255), 0, 0, 0, 23, 1, 0)};
        directed = {directed, known(cmd(ACT_MOVEROW, -255), 0, 0, 0, 0, 1, 0)};
        directed = {directed, cmd(ACT_MOVECOL, 1)};
        directed = {directed, cmd(ACT_READ, 16'h0000)};
        directed = {directed, cmd(ACT_ERASERIGHT, 0)};
        directed = {directed, cmd(ACT_DELLINES, 255)};
        directed = {directed, cmd(ACT_DELCHARS, 3)};
        directed = {directed, cmd(ACT_DELCHARS, 0)};
        directed = {directed, cmd(ACT_ERASEBELOW, 0)};
        // The erase-all gate: closed, one rearmed erase, then a blocked one.
        directed = {directed, cmd(ACT_ENABLE, 0)};
        directed = {directed, cmd(ACT_ERASEALL, 0)};
        directed = {directed, cmd(ACT_ERASEALL, 0)};
        directed = {directed, cmd(ACT_ENABLE, 1)};
        directed = {directed, cmd(ACT_NOP15, 0)};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_screen(80, 24);
        foreach (directed[i])
            send(directed[i].it, directed[i].has_exp, directed[i].exp);

        for (int ph = 0; ph < 12; ph++) begin
            set_screen(sizes[ph][0], sizes[ph][1]);
            n = (sizes[ph][0] * sizes[ph][1] > 512) ? 40 : 95;
            for (int k = 0; k < n; k++)
                send(random_cmd(), 1'b0, '{default: '0});
        end

        @(posedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
